// ----- hdl/pcep_pkg.sv -----
package pcep_pkg;

    // Code table geometry
    localparam int MAX_CODE_BITS = 32;
    localparam int ALPHABET_SIZE = 256;
    localparam int TABLE_DEPTH   = 256;
    localparam int SYM_W         = 8;
    localparam int CODE_W        = 32;
    localparam int LEN_W         = 6;
    localparam int PEND_W        = 7;
    localparam int PCNT_W        = 3;
    localparam int ACC_W         = PEND_W + CODE_W;

    // Longest code that is kept in the table
    localparam logic [LEN_W-1:0] CODE_CAP =
        LEN_W'((MAX_CODE_BITS < CODE_W) ? MAX_CODE_BITS : CODE_W);

    // Operation codes
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_ENCODE = 2'd1;
    localparam logic [1:0] OP_FLUSH  = 2'd2;

    typedef struct packed {
        logic [1:0]        operation;
        logic [SYM_W-1:0]  symbol;
        logic [CODE_W-1:0] code_value;
        logic [LEN_W-1:0]  code_length;
    } t_in_item;

    typedef struct packed {
        logic [7:0] packed_byte;
        logic       byte_valid;
        logic       missing_symbol;
        logic       last;
    } t_out_item;

    // Job handed to the packer
    typedef enum logic [1:0] {
        JOB_ENCODE = 2'd0,
        JOB_FLUSH  = 2'd1,
        JOB_ERROR  = 2'd2
    } t_job;

    typedef struct packed {
        logic              valid;
        t_job              job;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } t_pk_cmd;

    // Keep only the low len bits of a code
    function automatic logic [CODE_W-1:0] mask_code(input logic [CODE_W-1:0] value,
                                                    input logic [LEN_W-1:0]  len);
        logic [CODE_W:0] mask;
        mask = ((CODE_W+1)'(1) << len) - (CODE_W+1)'(1);
        return value & mask[CODE_W-1:0];
    endfunction

endpackage

// ----- hdl/pcep_table.sv -----
module pcep_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr_en,
    input  logic                          i_rd_en,
    input  logic [pcep_pkg::SYM_W-1:0]    i_addr,
    input  logic [pcep_pkg::CODE_W-1:0]   i_wr_code,
    input  logic [pcep_pkg::LEN_W-1:0]   i_wr_len,
    output logic                          o_present,
    output logic [pcep_pkg::CODE_W-1:0]   o_rd_code,
    output logic [pcep_pkg::LEN_W-1:0]    o_rd_len
);
    import pcep_pkg::*;

    logic [LEN_W+CODE_W-1:0] mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]  r_present;
    logic [LEN_W+CODE_W-1:0] r_rd_data;
    logic                    in_range;
    logic [LEN_W-1:0]        sat_len;

    assign in_range  = 32'(i_addr) < ALPHABET_SIZE;
    assign o_present = in_range && r_present[i_addr];
    assign sat_len   = (i_wr_len > CODE_CAP) ? CODE_CAP : i_wr_len;

    // Presence bits, cleared at reset; zero length removes the entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= '0;
        end else if (i_wr_en && in_range) begin
            r_present[i_addr] <= (i_wr_len != '0);
        end
    end

    // Code store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en && in_range && i_wr_len != '0) begin
            mem[i_addr] <= {sat_len, mask_code(i_wr_code, sat_len)};
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_addr];
        end
    end

    assign o_rd_code = r_rd_data[CODE_W-1:0];
    assign o_rd_len  = r_rd_data[LEN_W+CODE_W-1:CODE_W];

endmodule

// ----- hdl/pcep_packer.sv -----
module pcep_packer (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pcep_pkg::t_pk_cmd     i_cmd,
    output logic                  o_busy,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output pcep_pkg::t_out_item   o_out_data
);
    import pcep_pkg::*;

    typedef enum logic [1:0] {
        P_IDLE = 2'b01,
        P_EMIT = 2'b10
    } t_pstate;

    t_pstate           r_state, n_state;
    t_job              r_job, n_job;
    logic [ACC_W-1:0]  r_acc, n_acc;
    logic [LEN_W-1:0]  r_cnt, n_cnt;
    logic [PEND_W-1:0] r_pbits, n_pbits;
    logic [PCNT_W-1:0] r_pcnt, n_pcnt;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;

    logic              slot_free;
    logic [ACC_W-1:0]  sum_acc;
    logic [LEN_W-1:0]  sum_cnt;
    logic [LEN_W-1:0]  rem_cnt;
    logic [ACC_W-1:0]  shifted;
    logic [7:0]        flush_byte;

    assign slot_free = !r_out_valid || i_out_ready;
    assign o_busy    = (r_state != P_IDLE);

    // Append new code after the pending bits
    assign sum_acc    = (ACC_W'(r_pbits) << i_cmd.len) | ACC_W'(i_cmd.code);
    assign sum_cnt    = LEN_W'(r_pcnt) + i_cmd.len;
    assign rem_cnt    = r_cnt - LEN_W'(8);
    assign shifted    = r_acc >> rem_cnt;
    assign flush_byte = {1'b0, r_pbits} << (4'd8 - {1'b0, r_pcnt});

    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_acc       = r_acc;
        n_cnt       = r_cnt;
        n_pbits     = r_pbits;
        n_pcnt      = r_pcnt;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        unique case (r_state)
            P_IDLE: begin
                if (i_cmd.valid) begin
                    n_job = i_cmd.job;
                    if (i_cmd.job == JOB_ENCODE && sum_cnt < LEN_W'(8)) begin
                        // No byte completes: just keep the bits
                        n_pcnt  = sum_cnt[PCNT_W-1:0];
                        n_pbits = sum_acc[PEND_W-1:0] & ~(PEND_W'('1) << sum_cnt[PCNT_W-1:0]);
                    end else begin
                        n_acc   = sum_acc;
                        n_cnt   = sum_cnt;
                        n_state = P_EMIT;
                    end
                end
            end
            P_EMIT: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    unique case (r_job)
                        JOB_ENCODE: begin
                            // One byte per cycle while the output slot is free, oldest first
                            n_out = '{packed_byte: shifted[7:0], byte_valid: 1'b1,
                                      missing_symbol: 1'b0,
                                      last: (rem_cnt < LEN_W'(8))};
                            n_cnt = rem_cnt;
                            if (rem_cnt < LEN_W'(8)) begin
                                n_pcnt  = rem_cnt[PCNT_W-1:0];
                                n_pbits = r_acc[PEND_W-1:0]
                                        & ~(PEND_W'('1) << rem_cnt[PCNT_W-1:0]);
                                n_state = P_IDLE;
                            end
                        end
                        JOB_FLUSH: begin
                            if (r_pcnt != '0) begin
                                n_out = '{packed_byte: flush_byte, byte_valid: 1'b1,
                                          missing_symbol: 1'b0, last: 1'b1};
                            end else begin
                                n_out = '{packed_byte: 8'd0, byte_valid: 1'b0,
                                          missing_symbol: 1'b0, last: 1'b1};
                            end
                            n_pbits = '0;
                            n_pcnt  = '0;
                            n_state = P_IDLE;
                        end
                        default: begin
                            // Missing symbol: error result, bit buffer untouched
                            n_out = '{packed_byte: 8'd0, byte_valid: 1'b0,
                                      missing_symbol: 1'b1, last: 1'b1};
                            n_state = P_IDLE;
                        end
                    endcase
                end
            end
            default: n_state = P_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= P_IDLE;
            r_pbits     <= '0;
            r_pcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pbits     <= n_pbits;
            r_pcnt      <= n_pcnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        r_acc <= n_acc;
        r_cnt <= n_cnt;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- hdl/prefix_code_encode_pack.sv -----
// Prefix-code encoder with bit packer.
// Input channel (i_in_valid / o_in_ready / i_in_data) carries load, encode and
// flush items. Output channel (o_out_valid / i_out_ready / o_out_data) carries
// packed bytes, error results and end markers; last marks each item's final one.
// A load writes one entry of the 256-entry code table.
// An encode first does a synchronous table read, then the packer sends 0 to
// 4 bytes, one byte per cycle while the receiver is ready, through its
// one-byte output register. A missing symbol or a flush gives one result.
// Items are handled one at a time: o_in_ready drops while a result is still
// being produced.
// Reset (i_rst_n low, synchronous) marks every table entry empty and clears
// the bit buffer and the output valid flag; no clearing pass is needed.
// When the receiver stalls, the output register holds its transfer and the
// packer waits, which in turn holds o_in_ready low.
module prefix_code_encode_pack (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  pcep_pkg::t_in_item    i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output pcep_pkg::t_out_item   o_out_data
);
    import pcep_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    t_state   r_state, n_state;
    logic     accept;
    logic     pk_busy;
    logic     present;
    logic     tbl_wr;
    logic     tbl_rd;
    logic [CODE_W-1:0] rd_code;
    logic [LEN_W-1:0]  rd_len;
    t_pk_cmd  pk_cmd;

    assign o_in_ready = (r_state == S_IDLE) && !pk_busy;
    assign accept     = i_in_valid && o_in_ready;
    assign tbl_wr     = accept && i_in_data.operation == OP_LOAD;
    assign tbl_rd     = accept && i_in_data.operation == OP_ENCODE && present;

    // Sequencer: issue table access, then hand the job to the packer
    always_comb begin
        n_state       = r_state;
        pk_cmd.valid  = 1'b0;
        pk_cmd.job    = JOB_ENCODE;
        pk_cmd.code   = rd_code;
        pk_cmd.len    = rd_len;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in_data.operation == OP_ENCODE) begin
                        if (present) begin
                            n_state = S_READ;
                        end else begin
                            pk_cmd.valid = 1'b1;
                            pk_cmd.job   = JOB_ERROR;
                        end
                    end else if (i_in_data.operation == OP_FLUSH) begin
                        pk_cmd.valid = 1'b1;
                        pk_cmd.job   = JOB_FLUSH;
                    end
                end
            end
            S_READ: begin
                pk_cmd.valid = 1'b1;
                pk_cmd.job   = JOB_ENCODE;
                n_state      = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    pcep_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (tbl_wr),
        .i_rd_en   (tbl_rd),
        .i_addr    (i_in_data.symbol),
        .i_wr_code (i_in_data.code_value),
        .i_wr_len  (i_in_data.code_length),
        .o_present (present),
        .o_rd_code (rd_code),
        .o_rd_len  (rd_len)
    );

    pcep_packer u_packer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (pk_cmd),
        .o_busy      (pk_busy),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- bench/prefix_code_encode_pack_tb.sv -----
`timescale 1ns / 1ps

module prefix_code_encode_pack_tb;
    import pcep_pkg::*;

    localparam int IDLE_LIMIT   = 3000;
    localparam int TAIL_CYCLES  = 20;
    localparam int QUIET_CYCLES = 12;
    localparam int RAND_ITEMS   = 430;
    localparam int LONG_HOLD    = 400;

    typedef struct {
        t_in_item item;
        bit       wait_drain;
    } t_send_item;

    logic      i_clk;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_data;

    prefix_code_encode_pack uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Code table and bit buffer as the block should hold them
    logic [CODE_W-1:0] tbl_code  [TABLE_DEPTH];
    logic [LEN_W-1:0]  tbl_len   [TABLE_DEPTH];
    bit                tbl_valid [TABLE_DEPTH];
    logic [PEND_W-1:0] buf_bits = '0;
    logic [PCNT_W-1:0] buf_cnt  = '0;

    t_out_item  byte_stream_q[$];   // results still owed by the block
    t_send_item send_q[$];          // items not yet offered
    logic [7:0] loaded_syms[$];     // symbols the generator has loaded

    int in_taken    = 0;
    int in_offered  = 0;
    int out_cnt     = 0;
    int err_cnt     = 0;
    int idle_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        for (int s = 0; s < TABLE_DEPTH; s++) begin
            tbl_valid[s] = 1'b0;
            tbl_code[s]  = '0;
            tbl_len[s]   = '0;
        end
    end

    // Apply one accepted item to the table and bit buffer and queue its expected results
    task automatic pack_predict(input t_in_item it);
        logic [CODE_W:0]   mask;
        logic [ACC_W-1:0]  acc;
        logic [LEN_W-1:0]  len;
        int                total;
        int                nbytes;
        t_out_item         r;
        case (it.operation)
            OP_LOAD: begin
                if (int'(it.symbol) < ALPHABET_SIZE) begin
                    if (it.code_length == '0) begin
                        tbl_valid[it.symbol] = 1'b0;
                    end else begin
                        len  = (it.code_length > CODE_CAP) ? CODE_CAP : it.code_length;
                        mask = ((CODE_W+1)'(1) << len) - (CODE_W+1)'(1);
                        tbl_code[it.symbol]  = it.code_value & mask[CODE_W-1:0];
                        tbl_len[it.symbol]   = len;
                        tbl_valid[it.symbol] = 1'b1;
                    end
                end
            end
            OP_ENCODE: begin
                if (int'(it.symbol) >= ALPHABET_SIZE || !tbl_valid[it.symbol]) begin
                    r.packed_byte    = 8'h00;
                    r.byte_valid     = 1'b0;
                    r.missing_symbol = 1'b1;
                    r.last           = 1'b1;
                    byte_stream_q.push_back(r);
                end else begin
                    len    = tbl_len[it.symbol];
                    acc    = (ACC_W'(buf_bits) << len) | ACC_W'(tbl_code[it.symbol]);
                    total  = int'(buf_cnt) + int'(len);
                    nbytes = total / 8;
                    for (int i = 0; i < nbytes; i++) begin
                        r.packed_byte    = 8'(acc >> (total - 8 * (i + 1)));
                        r.byte_valid     = 1'b1;
                        r.missing_symbol = 1'b0;
                        r.last           = (i == nbytes - 1);
                        byte_stream_q.push_back(r);
                    end
                    total    = total - 8 * nbytes;
                    buf_cnt  = PCNT_W'(total);
                    buf_bits = PEND_W'(acc & ((ACC_W'(1) << total) - ACC_W'(1)));
                end
            end
            OP_FLUSH: begin
                r.missing_symbol = 1'b0;
                r.last           = 1'b1;
                if (buf_cnt == '0) begin
                    r.packed_byte = 8'h00;
                    r.byte_valid  = 1'b0;
                end else begin
                    r.packed_byte = 8'({1'b0, buf_bits} << (8 - int'(buf_cnt)));
                    r.byte_valid  = 1'b1;
                end
                byte_stream_q.push_back(r);
                buf_bits = '0;
                buf_cnt  = '0;
            end
            default: begin
                // unused operation: ignored
            end
        endcase
    endtask

    task automatic report_mismatch(input t_out_item want, input t_out_item got,
                                   input bit have_want);
        err_cnt++;
        if (err_cnt <= 10) begin
            if (have_want)
                $display({"result %0d: expected byte=%02h valid=%b missing=%b last=%b,",
                          " got byte=%02h valid=%b missing=%b last=%b"},
                         out_cnt, want.packed_byte, want.byte_valid, want.missing_symbol,
                         want.last, got.packed_byte, got.byte_valid, got.missing_symbol,
                         got.last);
            else
                $display("result %0d: none expected, got byte=%02h valid=%b missing=%b last=%b",
                         out_cnt, got.packed_byte, got.byte_valid, got.missing_symbol,
                         got.last);
        end
    endtask

    // Monitor: predict on input transfers, check output transfers
    always @(posedge i_clk) begin
        t_out_item want;
        bit        moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                pack_predict(i_in_data);
                in_taken <= in_taken + 1;
                moved = 1'b1;
            end
            if (o_out_valid && i_out_ready) begin
                moved = 1'b1;
                if (byte_stream_q.size() == 0) begin
                    report_mismatch(o_out_data, o_out_data, 1'b0);
                end else begin
                    want = byte_stream_q.pop_front();
                    if (want.packed_byte !== o_out_data.packed_byte ||
                        want.byte_valid !== o_out_data.byte_valid ||
                        want.missing_symbol !== o_out_data.missing_symbol ||
                        want.last !== o_out_data.last)
                        report_mismatch(want, o_out_data, 1'b1);
                end
                out_cnt <= out_cnt + 1;
            end
            idle_cycles <= moved ? 0 : idle_cycles + 1;
        end
    end

    // Driver: bursts with random gaps, optional wait for a drained block
    int burst_left = 1;
    int gap_left   = 0;
    int quiet      = 0;
    always @(negedge i_clk) begin
        t_send_item nxt;
        if (i_rst_n) begin
            if (byte_stream_q.size() == 0 && in_taken == in_offered)
                quiet++;
            else
                quiet = 0;
            if (!(i_in_valid && in_taken != in_offered)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (send_q.size() != 0 &&
                             (!send_q[0].wait_drain || quiet >= QUIET_CYCLES)) begin
                    nxt = send_q.pop_front();
                    i_in_data  <= nxt.item;
                    i_in_valid <= 1'b1;
                    in_offered++;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 20);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: own stall pattern plus one long hold-off
    int  hold_left = 0;
    int  seg_left  = 0;
    int  rx_mode   = 0;
    bit  long_hold_done = 1'b0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (!long_hold_done && out_cnt >= 150) begin
            long_hold_done = 1'b1;
            hold_left      = LONG_HOLD;
            i_out_ready <= 1'b0;
        end else begin
            if (seg_left == 0) begin
                rx_mode  = $urandom_range(0, 2);
                seg_left = $urandom_range(10, 60);
            end else begin
                seg_left--;
            end
            case (rx_mode)
                0:       i_out_ready <= 1'b1;
                1:       i_out_ready <= ($urandom_range(0, 1) == 0);
                default: i_out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic add_item(input logic [1:0] op, input logic [7:0] sym,
                            input logic [31:0] val, input logic [5:0] len,
                            input bit drain);
        t_send_item s;
        s.item.operation   = op;
        s.item.symbol      = sym;
        s.item.code_value  = val;
        s.item.code_length = len;
        s.wait_drain       = drain;
        send_q.push_back(s);
        if (op == OP_LOAD && len != '0)
            loaded_syms.push_back(sym);
    endtask

    // Mostly short codes, some long, a few saturating, rare removal
    function automatic logic [5:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 6'($urandom_range(1, 8));
        else if (r < 88)
            return 6'($urandom_range(9, 32));
        else if (r < 96)
            return 6'($urandom_range(33, 63));
        return 6'd0;
    endfunction

    // Stimulus and end of run
    initial begin
        int         n_real;
        int         r;
        logic [7:0] sym;
        // directed: empty table, extremes, saturation, masking, removal
        add_item(OP_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b0);
        add_item(OP_ENCODE, 8'h00, 32'hFFFF_FFFF, 6'd63, 1'b0);
        add_item(OP_LOAD,   8'h00, 32'hFFFF_FFFF, 6'd63, 1'b0);
        add_item(OP_ENCODE, 8'h00, 32'h0000_0000, 6'd0,  1'b0);
        add_item(OP_LOAD,   8'hFF, 32'h0000_0000, 6'd1,  1'b0);
        add_item(OP_LOAD,   8'h5A, 32'hFFFF_FFF5, 6'd3,  1'b0);
        add_item(OP_ENCODE, 8'h5A, 32'h0000_0000, 6'd0,  1'b0);
        add_item(OP_ENCODE, 8'hFF, 32'h0000_0000, 6'd0,  1'b0);
        add_item(OP_FLUSH,  8'hFF, 32'hFFFF_FFFF, 6'd63, 1'b0);
        add_item(OP_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b0);
        add_item(OP_LOAD,   8'hA5, 32'h8000_0001, 6'd33, 1'b0);
        add_item(OP_ENCODE, 8'h5A, 32'h0000_0000, 6'd0,  1'b0);
        add_item(OP_ENCODE, 8'hA5, 32'h0000_0000, 6'd0,  1'b0);
        add_item(OP_LOAD,   8'h5A, 32'hFFFF_FFFF, 6'd0,  1'b0);
        add_item(OP_ENCODE, 8'h5A, 32'h0000_0000, 6'd0,  1'b0);
        add_item(2'd3,      8'h5A, 32'hFFFF_FFFF, 6'd63, 1'b0);
        add_item(OP_LOAD,   8'h01, 32'h0000_0081, 6'd8,  1'b0);
        add_item(OP_ENCODE, 8'h01, 32'h0000_0000, 6'd0,  1'b0);
        add_item(OP_ENCODE, 8'hFF, 32'h0000_0000, 6'd0,  1'b0);
        add_item(OP_ENCODE, 8'hA5, 32'h0000_0000, 6'd0,  1'b0);
        add_item(OP_ENCODE, 8'h00, 32'h0000_0000, 6'd0,  1'b0);
        add_item(OP_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b0);
        add_item(OP_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b0);

        // random: fill part of the table, then mostly encodes of loaded symbols
        for (int k = 0; k < 40; k++)
            add_item(OP_LOAD, 8'($urandom_range(0, 255)), $urandom, pick_len(), k == 0);
        n_real = 0;
        while (n_real < RAND_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 55 && loaded_syms.size() != 0) begin
                sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
                add_item(OP_ENCODE, sym, $urandom, 6'($urandom), n_real == 250);
            end else if (r < 62) begin
                add_item(OP_ENCODE, 8'($urandom), $urandom, 6'($urandom), n_real == 250);
            end else if (r < 77) begin
                add_item(OP_LOAD, 8'($urandom), $urandom, pick_len(), n_real == 250);
            end else if (r < 90) begin
                add_item(OP_FLUSH, 8'($urandom), $urandom, 6'($urandom), n_real == 250);
            end else if (r < 95) begin
                add_item(2'd3, 8'($urandom), $urandom, 6'($urandom), 1'b0);
                n_real--;
            end else if (loaded_syms.size() != 0) begin
                sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
                add_item(OP_LOAD, sym, $urandom, 6'd0, n_real == 250);
            end else begin
                n_real--;
            end
            n_real++;
        end
        add_item(OP_FLUSH, 8'h00, 32'h0000_0000, 6'd0, 1'b0);

        // synchronous reset, released on a falling edge
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (send_q.size() != 0 || in_taken != in_offered || byte_stream_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        err_cnt += byte_stream_q.size();
        if (err_cnt == 0)
            $display("prefix_code_encode_pack: match");
        else
            $display("prefix_code_encode_pack: mismatch");
        $finish;
    end

    // Watchdog: no transfer on either side for too long
    initial begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge i_clk);
        $display("prefix_code_encode_pack: mismatch");
        $finish;
    end

endmodule
